// File: rtl/core/abs_pkg.sv
// abs_pkg: constants and types for the adaptive baseline subtract unit
// no dependencies; used by abs_mean and adaptive_baseline_subtract_unit
package abs_pkg;

  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 12;
  localparam int TOL_BITS    = 8;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(5);

  // held count reaches WINDOW, window sum stays below WINDOW * 2^SAMPLE_BITS
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CMP_W   = (SAMPLE_BITS > TOL_BITS) ? SAMPLE_BITS : TOL_BITS;
  localparam int CORR_W  = SAMPLE_BITS + 1;

  // reciprocal scaling: exact floor(sum / n) for every sum below 2^SUM_W
  localparam int RECIP_K = SUM_W + CNT_W;
  localparam int RECIP_W = RECIP_K + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [TOL_BITS-1:0]    tol_t;
  typedef logic [CORR_W-1:0]      corr_t;

endpackage

// File: rtl/core/abs_mean.sv
// abs_mean: floor(sum / count) for count in 1..WINDOW by reciprocal multiply
// depends on abs_pkg
module abs_mean (
  input  abs_pkg::sum_t    sum,
  input  abs_pkg::count_t  count,
  output abs_pkg::sample_t mean
);

  localparam int TAB_N = 2 ** abs_pkg::CNT_W;

  logic [abs_pkg::RECIP_W-1:0] recip_tab [TAB_N];
  logic [abs_pkg::RECIP_W-1:0] recip;
  logic [abs_pkg::PROD_W-1:0]  prod;

  // ceil(2^K / n) per count value
  for (genvar i = 0; i < TAB_N; i++) begin : g_recip
    localparam longint DIV = (i == 0) ? 1 : i;
    localparam longint RV  = ((64'd1 << abs_pkg::RECIP_K) + DIV - 1) / DIV;
    assign recip_tab[i] = abs_pkg::RECIP_W'(RV);
  end

  assign recip = recip_tab[count];
  assign prod  = abs_pkg::PROD_W'(sum) * abs_pkg::PROD_W'(recip);
  assign mean  = prod[abs_pkg::RECIP_K +: abs_pkg::SAMPLE_BITS];

endmodule

// File: rtl/core/adaptive_baseline_subtract_unit.sv
// adaptive_baseline_subtract_unit: top level, window test, baseline update
// depends on abs_pkg and abs_mean
//
// channel   signals                          payload
// item      item_valid / item_stall          sample, waveform_start
// result    result_valid / result_stall      corrected, baseline
// config    cfg_valid / cfg_ready            tolerance
//
// one transaction per cycle unless the result stalls; stages: input register,
// then window test, sum and reciprocal multiply into the result register
// the baseline loop closes through the multiplier in abs_mean
// reset is synchronous: history, count, sum and baseline clear, tolerance = 5
// a stalled result holds; the input register holds and stalls behind it
module adaptive_baseline_subtract_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  abs_pkg::sample_t      sample,
  input  logic                  waveform_start,
  output logic                  result_valid,
  input  logic                  result_stall,
  output abs_pkg::corr_t        corrected,
  output abs_pkg::sample_t      baseline,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  abs_pkg::tol_t         tolerance
);

  abs_pkg::tol_t    tol;
  logic             valid_a;
  abs_pkg::sample_t sample_a;
  logic             start_a;
  logic             advance;

  abs_pkg::sample_t history [abs_pkg::WINDOW];
  abs_pkg::sample_t window_next [abs_pkg::WINDOW];
  abs_pkg::count_t  held;
  abs_pkg::count_t  held_next;
  abs_pkg::sum_t    sum;
  abs_pkg::sum_t    sum_next;
  abs_pkg::sample_t run_base;
  abs_pkg::sample_t run_base_next;
  abs_pkg::sample_t mean;
  logic [abs_pkg::WINDOW-1:0] quiet_lane;
  logic             quiet;

  assign cfg_ready  = 1'b1;
  assign advance    = valid_a && !(result_valid && result_stall);
  assign item_stall = valid_a && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= abs_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol <= tolerance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (!item_stall) begin
      valid_a <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      sample_a <= sample;
      start_a  <= waveform_start;
    end
  end

  // window after this sample: newest first
  always_comb begin
    window_next[0] = sample_a;
    for (int i = 1; i < abs_pkg::WINDOW; i++) begin
      window_next[i] = start_a ? '0 : history[i-1];
    end
  end

  always_comb begin
    if (start_a) begin
      held_next = abs_pkg::CNT_W'(1);
    end else if (held < abs_pkg::CNT_W'(abs_pkg::WINDOW)) begin
      held_next = held + abs_pkg::CNT_W'(1);
    end else begin
      held_next = held;
    end
  end

  // running sum: entries beyond the held count are always zero
  always_comb begin
    logic [abs_pkg::SUM_W:0] acc;
    acc = {1'b0, sum} + (abs_pkg::SUM_W + 1)'(sample_a)
        - (abs_pkg::SUM_W + 1)'(history[abs_pkg::WINDOW-1]);
    sum_next = start_a ? abs_pkg::SUM_W'(sample_a) : acc[abs_pkg::SUM_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < abs_pkg::WINDOW; i++) begin
      logic [abs_pkg::CMP_W-1:0] a;
      logic [abs_pkg::CMP_W-1:0] b;
      logic [abs_pkg::CMP_W-1:0] gap;
      a    = abs_pkg::CMP_W'(window_next[i]);
      b    = abs_pkg::CMP_W'(run_base);
      gap  = (a >= b) ? (a - b) : (b - a);
      quiet_lane[i] = (abs_pkg::CNT_W'(i) >= held_next) || (gap < abs_pkg::CMP_W'(tol));
    end
    quiet = &quiet_lane;
  end

  abs_mean u_mean (
    .sum   (sum_next),
    .count (held_next),
    .mean  (mean)
  );

  always_comb begin
    if (start_a) begin
      run_base_next = sample_a;
    end else if (quiet) begin
      run_base_next = mean;
    end else begin
      run_base_next = run_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < abs_pkg::WINDOW; i++) begin
        history[i] <= '0;
      end
      held     <= '0;
      sum      <= '0;
      run_base <= '0;
    end else if (advance) begin
      history  <= window_next;
      held     <= held_next;
      sum      <= sum_next;
      run_base <= run_base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= advance || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      corrected <= {1'b0, sample_a} - {1'b0, run_base_next};
      baseline  <= run_base_next;
    end
  end

  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    held <= abs_pkg::CNT_W'(abs_pkg::WINDOW))
    else $error("held count above window");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (held == '0) |-> (sum == '0))
    else $error("nonzero sum with empty history");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && start_a) |=> (corrected == '0 && baseline == $past(sample_a)))
    else $error("waveform start did not set baseline");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (valid_a && result_valid))
    else $error("input stalled with room downstream");

endmodule
